// ----- rtl/core/srm_pkg.sv -----
// Shared types, constants and codes of the six-register machine runner.
package srm_pkg;

   localparam int REG_COUNT             = 6;
   localparam int PROGRAM_DEPTH_DEFAULT = 64;

   localparam int DATA_W  = 32;
   localparam int FUNC_W  = 2;
   localparam int IADDR_W = 6;
   localparam int OP_W    = 4;
   localparam int RIDX_W  = 3;
   localparam int LEN_W   = 7;
   localparam int STEP_W  = 20;
   // One bit more than the reported count so that the limit test never wraps.
   localparam int CNT_W   = STEP_W + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam logic [STEP_W-1:0] DEFAULT_STEP_LIMIT = STEP_W'(10000);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD   = 2'd0,
      FUNC_SETREG = 2'd1,
      FUNC_RUN    = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IP_BINDING     = 2'd0,
      CSR_PROGRAM_LENGTH = 2'd1,
      CSR_STEP_LIMIT     = 2'd2,
      CSR_UNUSED         = 2'd3
   } csr_index_type;

   typedef enum logic [OP_W-1:0] {
      OP_ADDR = 4'd0,
      OP_ADDI = 4'd1,
      OP_MULR = 4'd2,
      OP_MULI = 4'd3,
      OP_BANR = 4'd4,
      OP_BANI = 4'd5,
      OP_BORR = 4'd6,
      OP_BORI = 4'd7,
      OP_SETR = 4'd8,
      OP_SETI = 4'd9,
      OP_GTIR = 4'd10,
      OP_GTRI = 4'd11,
      OP_GTRR = 4'd12,
      OP_EQIR = 4'd13,
      OP_EQRI = 4'd14,
      OP_EQRR = 4'd15
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [DATA_W-1:0]   a;
      logic [DATA_W-1:0]   b;
      logic [RIDX_W-1:0]   c;
   } word_type;

   localparam int WORD_W = $bits(word_type);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_word;
      logic set_reg;
      logic reply_zero;
      logic run_start;
      logic copy_step;
      logic count;
      logic set_hit;
      logic latch_word;
      logic latch_a;
      logic exec;
      logic writeback;
      logic fin_dec;
      logic reply_run;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic copy_last;
      logic pc_halt;
      logic over_limit;
   } status_type;

endpackage

// ----- rtl/core/srm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module srm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/srm_ctrl.sv -----
// Controller state machine: sequences item handling and the fetch/execute loop.
module srm_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [srm_pkg::FUNC_W-1:0]  req_func,
   input  srm_pkg::status_type         status,
   output srm_pkg::cmd_type            cmd,
   output logic                        busy
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COPY,
      ST_FETCH,
      ST_WORD,
      ST_OPA,
      ST_EXEC,
      ST_WB,
      ST_FIN,
      ST_REPLY
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (srm_pkg::func_type'(req_func))
                  srm_pkg::FUNC_LOAD: begin
                     cmd.load_word  = 1'b1;
                     cmd.reply_zero = 1'b1;
                  end
                  srm_pkg::FUNC_SETREG: begin
                     cmd.set_reg    = 1'b1;
                     cmd.reply_zero = 1'b1;
                  end
                  srm_pkg::FUNC_RUN: begin
                     cmd.run_start = 1'b1;
                     state_in      = ST_COPY;
                  end
                  default: begin
                     cmd.reply_zero = 1'b1;
                  end
               endcase
            end
         end
         ST_COPY: begin
            cmd.copy_step = 1'b1;
            if (status.copy_last) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (status.pc_halt) begin
               state_in = ST_FIN;
            end else begin
               cmd.count = 1'b1;
               if (status.over_limit) begin
                  cmd.set_hit = 1'b1;
                  state_in    = ST_FIN;
               end else begin
                  state_in = ST_WORD;
               end
            end
         end
         ST_WORD: begin
            cmd.latch_word = 1'b1;
            state_in       = ST_OPA;
         end
         ST_OPA: begin
            cmd.latch_a = 1'b1;
            state_in    = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_WB;
         end
         ST_WB: begin
            cmd.writeback = 1'b1;
            state_in      = ST_FETCH;
         end
         ST_FIN: begin
            cmd.fin_dec = 1'b1;
            state_in    = ST_REPLY;
         end
         ST_REPLY: begin
            cmd.reply_run = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/core/srm_datapath.sv -----
// Datapath: program store, register files, ALU, step counter and result registers.
module srm_datapath #(
   parameter int PROGRAM_DEPTH = srm_pkg::PROGRAM_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  srm_pkg::cmd_type                cmd,
   output srm_pkg::status_type             status,
   input  logic [srm_pkg::IADDR_W-1:0]     req_instr_addr,
   input  logic [srm_pkg::OP_W-1:0]        req_opcode,
   input  logic [srm_pkg::DATA_W-1:0]      req_operand_a,
   input  logic [srm_pkg::DATA_W-1:0]      req_operand_b,
   input  logic [srm_pkg::RIDX_W-1:0]      req_operand_c,
   input  logic [srm_pkg::RIDX_W-1:0]      req_reg_index,
   input  logic [srm_pkg::DATA_W-1:0]      req_reg_value,
   input  logic                            csr_we,
   input  logic [srm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [srm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic                            rsp_valid,
   output logic [srm_pkg::STEP_W-1:0]      rsp_step_count,
   output logic [srm_pkg::DATA_W-1:0]      rsp_final_reg0,
   output logic                            rsp_hit_limit
);

   localparam int AW = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
   localparam int DW = srm_pkg::DATA_W;
   localparam int RW = srm_pkg::RIDX_W;

   // Configuration registers.
   logic [RW-1:0]               ip_binding_ff;
   logic [srm_pkg::LEN_W-1:0]   program_length_ff;
   logic [srm_pkg::STEP_W-1:0]  step_limit_ff;

   // Stored initial register values.
   logic [DW-1:0] mregs_ff [srm_pkg::REG_COUNT];

   // Run state.
   logic [RW-1:0]              copy_cnt_ff;
   logic [DW-1:0]              pc_ff;
   logic [srm_pkg::CNT_W-1:0]  steps_ff;
   logic                       hit_ff;
   srm_pkg::word_type          word_ff;
   logic [DW-1:0]              ra_ff;
   logic [DW-1:0]              v_ff;

   logic                       rsp_valid_ff;
   logic [srm_pkg::STEP_W-1:0] rsp_step_count_ff;
   logic [DW-1:0]              rsp_final_reg0_ff;
   logic                       rsp_hit_limit_ff;

   logic                ip_ok;
   logic [DW-1:0]       pc_val;
   logic [DW-1:0]       len_eff;
   logic                load_ok;
   logic [srm_pkg::WORD_W-1:0] prog_wdata;
   logic [srm_pkg::WORD_W-1:0] prog_rdata;
   srm_pkg::word_type   fetched;

   logic                work_we;
   logic [RW-1:0]       work_waddr;
   logic [DW-1:0]       work_wdata;
   logic [RW-1:0]       work_raddr;
   logic [DW-1:0]       work_q;

   logic [DW-1:0]       sel_a;
   logic [DW-1:0]       sel_b;
   logic [DW-1:0]       mul_b;
   logic [DW-1:0]       product;
   logic [DW-1:0]       alu_v;
   logic                dest_is_ip;

   assign ip_ok  = ip_binding_ff < RW'(srm_pkg::REG_COUNT);
   assign pc_val = ip_ok ? pc_ff : '0;

   // A program length above the store depth counts as the depth.
   assign len_eff = (DW'(program_length_ff) > DW'(PROGRAM_DEPTH)) ?
                    DW'(PROGRAM_DEPTH) : DW'(program_length_ff);

   assign status.pc_halt    = pc_val[DW-1] || (pc_val >= len_eff);
   assign status.over_limit = steps_ff > srm_pkg::CNT_W'(step_limit_ff);
   assign status.copy_last  = (copy_cnt_ff == RW'(srm_pkg::REG_COUNT - 1));

   // Program store.
   assign load_ok    = 32'(req_instr_addr) < 32'(PROGRAM_DEPTH);
   assign prog_wdata = {req_opcode, req_operand_a, req_operand_b, req_operand_c};
   assign fetched    = srm_pkg::word_type'(prog_rdata);

   srm_ram #(
      .WIDTH(srm_pkg::WORD_W),
      .DEPTH(PROGRAM_DEPTH)
   ) u_prog_ram (
      .clock(clock),
      .we   (cmd.load_word && load_ok),
      .waddr(AW'(req_instr_addr)),
      .wdata(prog_wdata),
      .raddr(AW'(pc_val)),
      .rdata(prog_rdata)
   );

   // Working register copy. The register bound to the pointer lives in pc_ff
   // during a run, so its entry in this store is stale and never read.
   assign dest_is_ip = ip_ok && (word_ff.c == ip_binding_ff);

   always_comb begin
      work_we    = 1'b0;
      work_waddr = copy_cnt_ff;
      work_wdata = mregs_ff[copy_cnt_ff];
      if (cmd.copy_step) begin
         work_we = 1'b1;
      end else if (cmd.writeback) begin
         work_we    = (word_ff.c < RW'(srm_pkg::REG_COUNT)) && !dest_is_ip;
         work_waddr = word_ff.c;
         work_wdata = v_ff;
      end
   end

   always_comb begin
      work_raddr = '0;
      if (cmd.latch_word) begin
         work_raddr = RW'(fetched.a);
      end else if (cmd.latch_a) begin
         work_raddr = RW'(word_ff.b);
      end
   end

   srm_ram #(
      .WIDTH(DW),
      .DEPTH(srm_pkg::REG_COUNT)
   ) u_work_ram (
      .clock(clock),
      .we   (work_we),
      .waddr(work_waddr),
      .wdata(work_wdata),
      .raddr(work_raddr),
      .rdata(work_q)
   );

   // Operand reads: the pointer register comes from pc_ff, bad indices read zero.
   always_comb begin
      if (ip_ok && (word_ff.a == DW'(ip_binding_ff))) begin
         sel_a = pc_ff;
      end else if (word_ff.a < DW'(srm_pkg::REG_COUNT)) begin
         sel_a = work_q;
      end else begin
         sel_a = '0;
      end
      if (ip_ok && (word_ff.b == DW'(ip_binding_ff))) begin
         sel_b = pc_ff;
      end else if (word_ff.b < DW'(srm_pkg::REG_COUNT)) begin
         sel_b = work_q;
      end else begin
         sel_b = '0;
      end
   end

   assign mul_b   = (word_ff.op == srm_pkg::OP_MULI) ? word_ff.b : sel_b;
   assign product = ra_ff * mul_b;

   always_comb begin
      case (word_ff.op)
         srm_pkg::OP_ADDR: alu_v = ra_ff + sel_b;
         srm_pkg::OP_ADDI: alu_v = ra_ff + word_ff.b;
         srm_pkg::OP_MULR: alu_v = product;
         srm_pkg::OP_MULI: alu_v = product;
         srm_pkg::OP_BANR: alu_v = ra_ff & sel_b;
         srm_pkg::OP_BANI: alu_v = ra_ff & word_ff.b;
         srm_pkg::OP_BORR: alu_v = ra_ff | sel_b;
         srm_pkg::OP_BORI: alu_v = ra_ff | word_ff.b;
         srm_pkg::OP_SETR: alu_v = ra_ff;
         srm_pkg::OP_SETI: alu_v = word_ff.a;
         srm_pkg::OP_GTIR: alu_v = DW'($signed(word_ff.a) > $signed(sel_b));
         srm_pkg::OP_GTRI: alu_v = DW'($signed(ra_ff) > $signed(word_ff.b));
         srm_pkg::OP_GTRR: alu_v = DW'($signed(ra_ff) > $signed(sel_b));
         srm_pkg::OP_EQIR: alu_v = DW'(word_ff.a == sel_b);
         srm_pkg::OP_EQRI: alu_v = DW'(ra_ff == word_ff.b);
         srm_pkg::OP_EQRR: alu_v = DW'(ra_ff == sel_b);
         default:          alu_v = '0;
      endcase
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ip_binding_ff     <= '0;
         program_length_ff <= '0;
         step_limit_ff     <= srm_pkg::DEFAULT_STEP_LIMIT;
         for (int i = 0; i < srm_pkg::REG_COUNT; i++) begin
            mregs_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (srm_pkg::csr_index_type'(csr_index))
               srm_pkg::CSR_IP_BINDING:     ip_binding_ff     <= RW'(csr_wdata);
               srm_pkg::CSR_PROGRAM_LENGTH: program_length_ff <= srm_pkg::LEN_W'(csr_wdata);
               srm_pkg::CSR_STEP_LIMIT:     step_limit_ff     <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (cmd.set_reg && (req_reg_index < RW'(srm_pkg::REG_COUNT))) begin
            mregs_ff[req_reg_index] <= req_reg_value;
         end
         rsp_valid_ff <= cmd.reply_zero || cmd.reply_run;
      end
   end

   // Run datapath registers.
   always_ff @(posedge clock) begin
      if (cmd.run_start) begin
         copy_cnt_ff <= '0;
         steps_ff    <= '0;
         hit_ff      <= 1'b0;
         pc_ff       <= '0;
      end
      if (cmd.copy_step) begin
         copy_cnt_ff <= copy_cnt_ff + 1'b1;
         if (copy_cnt_ff == ip_binding_ff) begin
            pc_ff <= mregs_ff[copy_cnt_ff];
         end
      end
      if (cmd.count) begin
         steps_ff <= steps_ff + 1'b1;
      end
      if (cmd.set_hit) begin
         hit_ff <= 1'b1;
      end
      if (cmd.latch_word) begin
         word_ff <= fetched;
      end
      if (cmd.latch_a) begin
         ra_ff <= sel_a;
      end
      if (cmd.exec) begin
         v_ff <= alu_v;
      end
      if (cmd.writeback) begin
         pc_ff <= (dest_is_ip ? v_ff : pc_ff) + 1'b1;
      end
      if (cmd.fin_dec) begin
         pc_ff <= pc_ff - 1'b1;
      end
      if (cmd.reply_zero) begin
         rsp_step_count_ff <= '0;
         rsp_final_reg0_ff <= '0;
         rsp_hit_limit_ff  <= 1'b0;
      end else if (cmd.reply_run) begin
         rsp_step_count_ff <= steps_ff[srm_pkg::STEP_W-1:0];
         rsp_final_reg0_ff <= (ip_binding_ff == '0) ? pc_ff : work_q;
         rsp_hit_limit_ff  <= hit_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_step_count = rsp_step_count_ff;
   assign rsp_final_reg0 = rsp_final_reg0_ff;
   assign rsp_hit_limit  = rsp_hit_limit_ff;

endmodule

// ----- rtl/core/six_register_machine_runner_top.sv -----
// Top level of the six-register machine runner.
//
// An item is taken when start is high and busy is low; every item gives one
// result, shown for a single cycle with rsp_valid high, and the receiver cannot
// stall it. Load, set-register and unused items leave busy low, and their result
// appears on the next cycle. A run copies the six initial registers into the
// working store, then takes each executed instruction through separate steps
// (pointer test and fetch, operand A read, operand B read, execute, write back),
// since the working registers sit in a one-read-port RAM, and ends with the final
// pointer test, the pointer decrement and the register 0 read; a run holds busy
// from the copy to the register 0 read, and its result follows in the cycle
// after busy falls.
module six_register_machine_runner_top #(
   parameter int PROGRAM_DEPTH = srm_pkg::PROGRAM_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [srm_pkg::FUNC_W-1:0]            req_func,
   input  logic [srm_pkg::IADDR_W-1:0]           req_instr_addr,
   input  logic [srm_pkg::OP_W-1:0]              req_opcode,
   input  logic signed [srm_pkg::DATA_W-1:0]     req_operand_a,
   input  logic signed [srm_pkg::DATA_W-1:0]     req_operand_b,
   input  logic [srm_pkg::RIDX_W-1:0]            req_operand_c,
   input  logic [srm_pkg::RIDX_W-1:0]            req_reg_index,
   input  logic signed [srm_pkg::DATA_W-1:0]     req_reg_value,
   output logic                                  rsp_valid,
   output logic [srm_pkg::STEP_W-1:0]            rsp_step_count,
   output logic signed [srm_pkg::DATA_W-1:0]     rsp_final_reg0,
   output logic                                  rsp_hit_limit,
   input  logic                                  csr_we,
   input  logic [srm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [srm_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   srm_pkg::cmd_type    cmd;
   srm_pkg::status_type status;

   srm_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_func(req_func),
      .status  (status),
      .cmd     (cmd),
      .busy    (busy)
   );

   srm_datapath #(
      .PROGRAM_DEPTH(PROGRAM_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_instr_addr(req_instr_addr),
      .req_opcode    (req_opcode),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .req_operand_c (req_operand_c),
      .req_reg_index (req_reg_index),
      .req_reg_value (req_reg_value),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_step_count(rsp_step_count),
      .rsp_final_reg0(rsp_final_reg0),
      .rsp_hit_limit (rsp_hit_limit)
   );

endmodule
